// ===== rtl/ftc_pkg.sv =====
// Shared constants and types for the FIFO fully associative tag cache.
package ftc_pkg;

    localparam int WAYS_DEF      = 16;
    localparam int ADDR_W        = 64;
    localparam int CNT_W         = 32;
    localparam int SHIFT_W       = 6;
    localparam int PDATA_W       = 32;
    localparam int PADDR_W       = 3;
    localparam int REG_IDX_W     = PADDR_W - 2;

    localparam logic [SHIFT_W-1:0]   TAG_SHIFT_RST = SHIFT_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_TAG_SHIFT = REG_IDX_W'(0);

    typedef struct packed {
        logic load;
        logic update;
    } t_dp_cmd;

endpackage

// ===== rtl/ftc_if.sv =====
// Valid/ready channels for address beats and result beats.
interface ftc_addr_if
    import ftc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface ftc_res_if
    import ftc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic             evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;

    modport source (output valid, output hit, output evicted, output hit_total,
                    output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input hit, input evicted, input hit_total,
                    input miss_total, input eviction_total, output ready);
endinterface

// ===== rtl/ftc_ctrl.sv =====
// Controller: sequences tag capture, lookup/update and the result register.
module ftc_ctrl
    import ftc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign fire        = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    assign o_cmd.load   = i_in_valid && o_in_ready;
    assign o_cmd.update = fire;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (fire) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ftc_dp.sv =====
// Datapath: tag store, FIFO pointers, parallel tag compare and counters.
module ftc_dp
    import ftc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [SHIFT_W-1:0] i_tag_shift,
    output logic               o_hit,
    output logic               o_evicted,
    output logic [CNT_W-1:0]   o_hit_total,
    output logic [CNT_W-1:0]   o_miss_total,
    output logic [CNT_W-1:0]   o_eviction_total
);

    localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int DW     = SLOT_W + 1;

    logic [ADDR_W-1:0] r_tag;
    logic [ADDR_W-1:0] r_store [WAYS];
    logic [SLOT_W-1:0] r_oldest;
    logic [FILL_W-1:0] r_fill;
    logic [CNT_W-1:0]  r_hits, r_misses, r_evicts;
    logic              r_hit, r_evicted;

    logic [WAYS-1:0]   match;
    logic              hit;
    logic              full;
    logic [DW-1:0]     wr_sum;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] oldest_inc;

    always_comb begin
        logic [DW-1:0] off;
        for (int j = 0; j < WAYS; j++) begin
            off = DW'(j) + DW'(WAYS) - DW'(r_oldest);
            if (off >= DW'(WAYS)) begin
                off = off - DW'(WAYS);
            end
            match[j] = (off < DW'(r_fill)) && (r_store[j] == r_tag);
        end
    end

    assign hit  = |match;
    assign full = (r_fill == FILL_W'(WAYS));

    always_comb begin
        wr_sum = DW'(r_oldest) + DW'(r_fill);
        if (wr_sum >= DW'(WAYS)) begin
            wr_sum = wr_sum - DW'(WAYS);
        end
        wr_slot = wr_sum[SLOT_W-1:0];
    end

    assign oldest_inc = (r_oldest == SLOT_W'(WAYS - 1)) ? '0 : r_oldest + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_address >> i_tag_shift;
        end
        if (i_cmd.update && !hit) begin
            r_store[wr_slot] <= r_tag;
        end
        if (i_cmd.update) begin
            r_hit     <= hit;
            r_evicted <= !hit && full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fill   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (i_cmd.update) begin
            if (hit) begin
                if (r_hits != '1) begin
                    r_hits <= r_hits + 1'b1;
                end
            end else begin
                if (r_misses != '1) begin
                    r_misses <= r_misses + 1'b1;
                end
                if (full) begin
                    r_oldest <= oldest_inc;
                    if (r_evicts != '1) begin
                        r_evicts <= r_evicts + 1'b1;
                    end
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    assign o_hit            = r_hit;
    assign o_evicted        = r_evicted;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WAYS))
        else $error("fill level above way count");

    a_hit_keeps_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && hit |=> $stable(r_fill) && $stable(r_oldest))
        else $error("hit moved FIFO pointers");

    a_miss_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && !hit |=> r_fill != '0)
        else $error("miss left store empty");

    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && !hit && full |=> r_evicted && (r_fill == FILL_W'(WAYS)))
        else $error("eviction flag or fill wrong on full miss");
`endif

endmodule

// ===== rtl/fifo_fully_associative_tag_cache.sv =====
// Top level: FIFO-replacement fully associative tag cache with APB config.
// An accepted address beat has its tag captured, then in S_LOOK it is compared against all ways
// and the store updated; S_LOOK waits while the previous result beat still waits unaccepted.
// The result is registered; no new address is taken until the current one has left S_LOOK.
// A new address is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the FIFO, clears counters, sets tag_shift to 4.
module fifo_fully_associative_tag_cache
    import ftc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ftc_addr_if.sink           i_addr,
    ftc_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SHIFT_W-1:0]   r_tag_shift;
    logic [REG_IDX_W-1:0] reg_idx;
    t_dp_cmd              cmd;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_TAG_SHIFT) ? PDATA_W'(r_tag_shift) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_shift <= TAG_SHIFT_RST;
        end else if (psel && penable && pwrite && pready && reg_idx == REG_TAG_SHIFT) begin
            r_tag_shift <= pwdata[SHIFT_W-1:0];
        end
    end

    ftc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_addr.valid),
        .o_in_ready  (i_addr.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    ftc_dp #(
        .WAYS (WAYS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_address        (i_addr.address),
        .i_tag_shift      (r_tag_shift),
        .o_hit            (o_res.hit),
        .o_evicted        (o_res.evicted),
        .o_hit_total      (o_res.hit_total),
        .o_miss_total     (o_res.miss_total),
        .o_eviction_total (o_res.eviction_total)
    );

endmodule
